/* rtl/mtsp_pkg.sv */
// ----------------------------------------------------------------------------
// mtsp_pkg
// Token codes, character constants and flag bit positions shared by the
// markup-to-style token parser modules.
// ----------------------------------------------------------------------------
package mtsp_pkg;

  localparam int MAX_TOKENS = 10;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = $clog2(MAX_TOKENS);

  // heading depth saturates here
  localparam logic [2:0] MAX_HEADING = 3'd6;

  typedef enum logic [4:0] {
    TOK_LIT        = 5'd0,
    TOK_SPAN_END   = 5'd1,
    TOK_ITALIC     = 5'd2,
    TOK_BOLD       = 5'd3,
    TOK_MONO       = 5'd4,
    TOK_SCAPS      = 5'd5,
    TOK_SUB        = 5'd6,
    TOK_SUP        = 5'd7,
    TOK_TITLE      = 5'd8,
    TOK_CODE       = 5'd9,
    TOK_PARA_END   = 5'd10,
    TOK_PARA_START = 5'd11,
    TOK_NBSP       = 5'd12,
    TOK_DASH       = 5'd13,
    TOK_SQ_OPEN    = 5'd14,
    TOK_SQ_CLOSE   = 5'd15,
    TOK_DQ_OPEN    = 5'd16,
    TOK_DQ_CLOSE   = 5'd17,
    TOK_AMP        = 5'd18
  } token_t;

  localparam token_t STYLE_START [4] = '{TOK_ITALIC, TOK_BOLD, TOK_MONO, TOK_SCAPS};

  // style flag bits
  localparam int S_ITALIC = 0;
  localparam int S_BOLD   = 1;
  localparam int S_MONO   = 2;
  localparam int S_SCAPS  = 3;
  localparam int S_SUB    = 4;
  localparam int S_SUP    = 5;

  // quote flag bits
  localparam int Q_DOUBLE = 0;
  localparam int Q_SINGLE = 1;

  // mark flag bits
  localparam int M_PARA  = 0;
  localparam int M_SPACE = 1;
  localparam int M_BREAK = 2;
  localparam int M_SKIP  = 3;

  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic plan_nz;
    logic at_last;
  } status_t;

endpackage

/* rtl/mtsp_ctrl.sv */
// ----------------------------------------------------------------------------
// mtsp_ctrl
// Handshake controller: accepts an item when idle or when the final token of
// the current item leaves, then steps the datapath through its token list.
// ----------------------------------------------------------------------------
module mtsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  mtsp_pkg::status_t status,
  output mtsp_pkg::cmd_t    cmd
);
  import mtsp_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t state;

  assign m_tvalid    = (state == ST_EMIT);
  assign cmd.advance = m_tvalid & m_tready;
  // take the next item in the same cycle the final token leaves
  assign s_tready    = (state == ST_IDLE) | (cmd.advance & status.at_last);
  assign cmd.load    = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= status.plan_nz ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (cmd.load) begin
            state <= status.plan_nz ? ST_EMIT : ST_IDLE;
          end else if (cmd.advance && status.at_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/mtsp_datapath.sv */
// ----------------------------------------------------------------------------
// mtsp_datapath
// Parser state, token list builder and token buffer with its read index.
// ----------------------------------------------------------------------------
module mtsp_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mtsp_pkg::cmd_t    cmd,
  input  logic              s_tuser,   // [0] kind
  input  logic [7:0]        s_tdata,   // [7:0] ch
  output mtsp_pkg::status_t status,
  output logic [15:0]       m_tdata,   // [7:0] char_out, [10:8] heading_level, zero pad
  output logic [4:0]        m_tuser,   // [4:0] token
  output logic              m_tlast
);
  import mtsp_pkg::*;

  logic [7:0] held;
  logic       started;
  logic [5:0] style;
  logic [1:0] quote;
  logic [2:0] depth;
  logic [3:0] mark;

  logic [7:0] held_next;
  logic       started_next;
  logic [5:0] style_next;
  logic [1:0] quote_next;
  logic [2:0] depth_next;
  logic [3:0] mark_next;

  token_t     plan_tok [MAX_TOKENS];
  logic [CNT_W-1:0] plan_cnt;
  logic [7:0] plan_chr;
  logic [2:0] plan_lvl;

  token_t     starts [4];
  logic [2:0] open_cnt;
  logic [1:0] sp;
  logic       reopen;
  logic [CNT_W-1:0] open_w;
  logic [CNT_W-1:0] kw;
  logic [CNT_W-1:0] sj;

  token_t     tok_buf [MAX_TOKENS];
  logic [CNT_W-1:0] buf_cnt;
  logic [IDX_W-1:0] idx;
  logic [7:0] out_chr;
  logic [2:0] out_lvl;
  token_t     cur_tok;

  logic [7:0] ch;
  assign ch = s_tdata;

  // compacted reopen list for a line break, in italic, bold, mono, small caps order
  always_comb begin
    sp = '0;
    for (int i = 0; i < 4; i++) begin
      starts[i] = TOK_ITALIC;
    end
    for (int i = 0; i < 4; i++) begin
      if (style[i]) begin
        starts[sp] = STYLE_START[i];
        sp = sp + 2'd1;
      end
    end
  end

  assign open_cnt = 3'(style[S_ITALIC]) + 3'(style[S_BOLD])
                  + 3'(style[S_MONO]) + 3'(style[S_SCAPS]);
  assign open_w   = CNT_W'(open_cnt);
  assign reopen   = (ch != CH_HASH) && (ch != CH_TILDE);

  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      plan_tok[k] = TOK_LIT;
    end
    plan_cnt     = '0;
    plan_chr     = '0;
    plan_lvl     = '0;
    kw           = '0;
    sj           = '0;
    held_next    = held;
    started_next = started;
    style_next   = style;
    quote_next   = quote;
    depth_next   = depth;
    mark_next    = mark;

    if (s_tuser) begin
      // end item: flush the held character, close the paragraph, reset
      if (started) begin
        plan_tok[0] = TOK_LIT;
        plan_chr    = held;
        plan_cnt    = CNT_W'(1);
        if (mark[M_PARA]) begin
          plan_tok[1] = TOK_PARA_END;
          plan_cnt    = CNT_W'(2);
        end
      end
      held_next    = '0;
      started_next = 1'b0;
      style_next   = '0;
      quote_next   = '0;
      depth_next   = '0;
      mark_next    = '0;
    end else if (!started) begin
      if (ch == CH_HASH) begin
        started_next = 1'b1;
        held_next    = CH_HASH;
      end
    end else begin
      held_next = ch;
      if (mark[M_SKIP]) begin
        mark_next[M_SKIP] = 1'b0;
      end else begin
        unique case (held)
          CH_STAR: begin
            plan_cnt = CNT_W'(1);
            if (ch == CH_STAR) begin
              plan_tok[0]        = style[S_BOLD] ? TOK_SPAN_END : TOK_BOLD;
              style_next[S_BOLD] = ~style[S_BOLD];
              mark_next[M_SKIP]  = 1'b1;
            end else begin
              plan_tok[0]          = style[S_ITALIC] ? TOK_SPAN_END : TOK_ITALIC;
              style_next[S_ITALIC] = ~style[S_ITALIC];
            end
          end
          CH_PIPE: begin
            plan_cnt           = CNT_W'(1);
            plan_tok[0]        = style[S_MONO] ? TOK_SPAN_END : TOK_MONO;
            style_next[S_MONO] = ~style[S_MONO];
          end
          CH_PLUS: begin
            plan_cnt            = CNT_W'(1);
            plan_tok[0]         = style[S_SCAPS] ? TOK_SPAN_END : TOK_SCAPS;
            style_next[S_SCAPS] = ~style[S_SCAPS];
          end
          CH_LT: begin
            plan_cnt = CNT_W'(1);
            if (style[S_SUB]) begin
              plan_tok[0]       = TOK_SPAN_END;
              style_next[S_SUB] = 1'b0;
            end else begin
              plan_tok[0]       = TOK_SUP;
              style_next[S_SUP] = 1'b1;
            end
          end
          CH_GT: begin
            plan_cnt = CNT_W'(1);
            if (style[S_SUP]) begin
              plan_tok[0]       = TOK_SPAN_END;
              style_next[S_SUP] = 1'b0;
            end else begin
              plan_tok[0]       = TOK_SUB;
              style_next[S_SUB] = 1'b1;
            end
          end
          CH_HASH: begin
            if (depth < MAX_HEADING) begin
              depth_next = depth + 3'd1;
            end
            if (ch != CH_HASH) begin
              plan_tok[0]       = TOK_TITLE;
              plan_lvl          = depth_next;
              plan_cnt          = CNT_W'(1);
              mark_next[M_PARA] = 1'b1;
            end
            if (ch == CH_SPACE) begin
              mark_next[M_SKIP] = 1'b1;
            end
          end
          CH_TILDE: begin
            if (!mark[M_PARA]) begin
              plan_tok[0]       = TOK_CODE;
              plan_cnt          = CNT_W'(1);
              mark_next[M_PARA] = 1'b1;
            end
          end
          CH_NL: begin
            // close open spans and the paragraph, reopen unless heading or code follows
            mark_next[M_BREAK] = 1'b1;
            mark_next[M_PARA]  = reopen;
            depth_next         = '0;
            for (int k = 0; k < MAX_TOKENS; k++) begin
              kw = CNT_W'(k);
              sj = kw - open_w - CNT_W'(2);
              if (kw < open_w) begin
                plan_tok[k] = TOK_SPAN_END;
              end else if (kw == open_w) begin
                plan_tok[k] = TOK_PARA_END;
              end else if (kw == open_w + CNT_W'(1)) begin
                plan_tok[k] = TOK_PARA_START;
              end else begin
                plan_tok[k] = starts[sj[1:0]];
              end
            end
            plan_cnt = open_w + CNT_W'(1) + (reopen ? open_w + CNT_W'(1) : CNT_W'(0));
          end
          CH_SPACE: begin
            mark_next[M_SPACE] = 1'b1;
            plan_cnt           = CNT_W'(1);
            if (ch == CH_EXCL || ch == CH_QUEST || ch == CH_COLON || ch == CH_SEMI) begin
              plan_tok[0] = TOK_NBSP;
            end else begin
              plan_tok[0] = TOK_LIT;
              plan_chr    = CH_SPACE;
            end
          end
          CH_SQUOTE: begin
            plan_cnt             = CNT_W'(1);
            plan_tok[0]          = quote[Q_SINGLE] ? TOK_SQ_CLOSE : TOK_SQ_OPEN;
            quote_next[Q_SINGLE] = ~quote[Q_SINGLE];
          end
          CH_DQUOTE: begin
            plan_cnt             = CNT_W'(1);
            plan_tok[0]          = quote[Q_DOUBLE] ? TOK_DQ_CLOSE : TOK_DQ_OPEN;
            quote_next[Q_DOUBLE] = ~quote[Q_DOUBLE];
          end
          CH_AMP: begin
            plan_cnt    = CNT_W'(1);
            plan_tok[0] = TOK_AMP;
          end
          CH_MINUS: begin
            plan_cnt = CNT_W'(1);
            if (mark[M_SPACE]) begin
              plan_tok[0] = TOK_DASH;
            end else if (mark[M_BREAK]) begin
              plan_tok[0]       = TOK_DASH;
              plan_tok[1]       = TOK_NBSP;
              plan_cnt          = CNT_W'(2);
              mark_next[M_SKIP] = 1'b1;
            end else begin
              plan_tok[0] = TOK_LIT;
              plan_chr    = CH_MINUS;
            end
          end
          CH_BSLASH: begin
            plan_cnt          = CNT_W'(1);
            plan_tok[0]       = TOK_LIT;
            plan_chr          = ch;
            mark_next[M_SKIP] = 1'b1;
          end
          default: begin
            plan_cnt           = CNT_W'(1);
            plan_tok[0]        = TOK_LIT;
            plan_chr           = held;
            mark_next[M_SPACE] = 1'b0;
            mark_next[M_BREAK] = 1'b0;
          end
        endcase
        // an apostrophe inside a word counts as an open single quote
        if (ch == CH_SQUOTE && !mark_next[M_SPACE] && !mark_next[M_BREAK]) begin
          quote_next[Q_SINGLE] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      started <= 1'b0;
      style   <= '0;
      quote   <= '0;
      depth   <= '0;
      mark    <= '0;
      buf_cnt <= '0;
      idx     <= '0;
    end else if (cmd.load) begin
      held    <= held_next;
      started <= started_next;
      style   <= style_next;
      quote   <= quote_next;
      depth   <= depth_next;
      mark    <= mark_next;
      buf_cnt <= plan_cnt;
      idx     <= '0;
    end else if (cmd.advance) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < MAX_TOKENS; k++) begin
        tok_buf[k] <= plan_tok[k];
      end
      out_chr <= plan_chr;
      out_lvl <= plan_lvl;
    end
  end

  assign cur_tok        = tok_buf[idx];
  assign status.plan_nz = (plan_cnt != '0);
  assign status.at_last = (CNT_W'(idx) == buf_cnt - CNT_W'(1));
  assign m_tuser        = cur_tok;
  assign m_tlast        = status.at_last;
  assign m_tdata        = {5'b0,
                           (cur_tok == TOK_TITLE) ? out_lvl : 3'b0,
                           (cur_tok == TOK_LIT) ? out_chr : 8'b0};

endmodule

/* rtl/markup_to_style_token_parser.sv */
// ----------------------------------------------------------------------------
// markup_to_style_token_parser
// Turns a markup character stream into style tokens and literal characters.
//
// Input channel (s_*): one character per item in s_tdata, s_tuser = 1 marks
// the end of input. A character is acted on when the next one arrives, so the
// tokens it causes leave one item later. Characters before the first '#' are
// dropped; the end item flushes the held character and closes the paragraph.
// Output channel (m_*): one token per item, m_tlast on the final token caused
// by an input item. An input item that causes no token produces no output.
// Timing: an item is accepted, its tokens leave one per cycle from the next
// cycle on while m_tready is high; the next item is taken in the cycle its
// predecessor's final token is taken. Most items cause one token, a line
// break up to ten. Reset clears all parser state and drops any tokens not
// yet taken. When the receiver stalls, the current token holds and s_tready
// stays low.
// ----------------------------------------------------------------------------
module markup_to_style_token_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] char_out, [10:8] heading_level, zero pad
  output logic [4:0]  m_tuser,   // [4:0] token
  output logic        m_tlast
);
  import mtsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mtsp_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  // a new item only overlaps output when the final token is leaving
  a_accept_overlap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid) |-> (m_tready && m_tlast))
    else $error("item accepted while tokens still pending");

  // an item with no tokens leaves the output idle
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !status.plan_nz) |=> !m_tvalid)
    else $error("output valid after item with no tokens");

  // only defined token codes leave
  a_token_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= TOK_AMP))
    else $error("token code out of range");

  // level is nonzero only on a title token
  a_level_title: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[10:8] != 3'd0)) |-> (m_tuser == TOK_TITLE))
    else $error("heading level on non-title token");
`endif

endmodule
